@@ src/bps_pkg.sv @@
// Shared types and constants for the bit slicer with preamble sync
package bps_pkg;

   // Preamble length in bits (alternating, starting with one)
   localparam int PREAMBLE_BITS = 8;
   // Quiet bit periods needed before the preamble search starts
   localparam int QUIET_BITS    = 5;

   // Field widths
   localparam int SPB_W   = 10;
   localparam int THR_W   = 10;
   localparam int LEN_W   = 12;
   localparam int BC_W    = 6;
   localparam int ERR_W   = 12;
   localparam int MCNT_W  = 16;
   localparam int CSR_W   = 12;
   localparam int CIDX_W  = 2;
   localparam int BURST_W = $clog2(PREAMBLE_BITS);

   // Configuration register indexes
   localparam logic [CIDX_W-1:0] CSR_SAMPLES_PER_BIT = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_BIT_THRESHOLD   = 2'd1;
   localparam logic [CIDX_W-1:0] CSR_MSG_LENGTH      = 2'd2;

   // Result queue depth
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // One queue entry: a single result beat, or a whole preamble burst
   typedef struct packed {
      logic              burst;
      logic              data_bit;
      logic [LEN_W-1:0]  bit_index;
      logic              last;
      logic [ERR_W-1:0]  bit_errors;
      logic [MCNT_W-1:0] message_count;
   } q_entry_type;

   // Slicer to queue write request
   typedef struct packed {
      logic        push;
      q_entry_type entry;
   } q_write_type;

endpackage

@@ src/bps_slicer.sv @@
// Sample register, integrate-and-dump slicer and preamble/message sequencing
module bps_slicer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_sample_bit,
   input  logic                      csr_valid,
   input  logic [bps_pkg::CIDX_W-1:0] csr_index,
   input  logic [bps_pkg::CSR_W-1:0]  csr_data,
   input  logic                      q_full,
   output bps_pkg::q_write_type       q_wr
);
   import bps_pkg::*;

   localparam logic [1:0] PH_UNSYNC = 2'd0;
   localparam logic [1:0] PH_IDLE   = 2'd1;
   localparam logic [1:0] PH_MSG    = 2'd2;

   localparam logic [BC_W-1:0]  PRE_BC   = BC_W'(PREAMBLE_BITS);
   localparam logic [BC_W-1:0]  QUIET_BC = BC_W'(QUIET_BITS);
   localparam logic [LEN_W-1:0] PRE_IDX  = LEN_W'(PREAMBLE_BITS);
   localparam logic [LEN_W-1:0] MIN_LEN  = LEN_W'(PREAMBLE_BITS + 1);
   localparam logic [THR_W-1:0] ONES_MAX = {THR_W{1'b1}};

   // Configuration registers
   logic [SPB_W-1:0] spb_ff;
   logic [THR_W-1:0] thr_ff;
   logic [LEN_W-1:0] len_ff;

   // Input sample register
   logic in_valid_ff, in_valid_in;
   logic in_sample_ff;
   logic advance;

   // Slicer state
   logic [1:0]        phase_ff, phase_in;
   logic [SPB_W-1:0]  sc_ff, sc_in;
   logic [THR_W-1:0]  ones_ff, ones_in;
   logic [BC_W-1:0]   bc_ff, bc_in;
   logic              quiet_ff, quiet_in;
   logic              expect_ff, expect_in;
   logic [LEN_W-1:0]  br_ff, br_in;
   logic [ERR_W-1:0]  mis_ff, mis_in;
   logic [MCNT_W-1:0] done_ff, done_in;

   // Datapath temporaries
   logic [SPB_W-1:0]  sc_inc;
   logic [THR_W-1:0]  ones_acc;
   logic              period_end;
   logic              dec_bit;
   logic [LEN_W-1:0]  eff_len;
   logic [BC_W-1:0]   bc_inc;
   logic [BC_W-1:0]   bc_step;
   logic              quiet_upd;
   logic [LEN_W-1:0]  br_inc;
   logic [ERR_W-1:0]  mis_acc;
   logic [MCNT_W-1:0] done_inc;

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff <= SPB_W'(8);
         thr_ff <= THR_W'(4);
         len_ff <= LEN_W'(64);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLES_PER_BIT: spb_ff <= csr_data[SPB_W-1:0];
            CSR_BIT_THRESHOLD:   thr_ff <= csr_data[THR_W-1:0];
            CSR_MSG_LENGTH:      len_ff <= csr_data[LEN_W-1:0];
            default:             ;
         endcase
      end
   end

   // Hold the sample until the queue has room for what it may produce
   assign advance   = in_valid_ff & ~q_full;
   assign req_stall = in_valid_ff & q_full;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid & ~req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid & ~req_stall) begin
         in_sample_ff <= req_sample_bit;
      end
   end

   // Integrate and dump
   assign sc_inc     = sc_ff + SPB_W'(1);
   assign ones_acc   = (in_sample_ff && ones_ff != ONES_MAX) ? ones_ff + THR_W'(1) : ones_ff;
   assign period_end = (sc_inc == spb_ff);
   assign dec_bit    = period_end & (ones_acc >= thr_ff);
   assign eff_len    = (len_ff < MIN_LEN) ? MIN_LEN : len_ff;
   assign bc_inc     = bc_ff + BC_W'(1);
   assign bc_step    = period_end ? bc_inc : bc_ff;
   assign quiet_upd  = quiet_ff & ~dec_bit;
   assign br_inc     = br_ff + LEN_W'(1);
   assign mis_acc    = mis_ff + ERR_W'(dec_bit == br_ff[0]);
   assign done_inc   = done_ff + MCNT_W'(1);

   // Advance phase, counters and build the queue entry
   always_comb begin
      phase_in  = phase_ff;
      sc_in     = sc_ff;
      ones_in   = ones_ff;
      bc_in     = bc_ff;
      quiet_in  = quiet_ff;
      expect_in = expect_ff;
      br_in     = br_ff;
      mis_in    = mis_ff;
      done_in   = done_ff;
      q_wr      = '0;
      if (advance) begin
         sc_in   = period_end ? '0 : sc_inc;
         ones_in = period_end ? '0 : ones_acc;
         case (phase_ff)
            PH_UNSYNC: begin
               bc_in    = bc_step;
               quiet_in = quiet_upd;
               if (bc_step >= QUIET_BC) begin
                  bc_in = '0;
                  if (quiet_upd) begin
                     phase_in = PH_IDLE;
                  end else begin
                     quiet_in = 1'b1;
                  end
               end
            end
            PH_IDLE: begin
               if (period_end) begin
                  if (dec_bit == expect_ff) begin
                     bc_in     = bc_inc;
                     expect_in = ~dec_bit;
                  end else begin
                     bc_in = '0;
                  end
               end
               if (bc_in == PRE_BC) begin
                  q_wr.push        = 1'b1;
                  q_wr.entry.burst = 1'b1;
                  bc_in            = '0;
                  br_in            = PRE_IDX;
                  mis_in           = '0;
                  phase_in         = PH_MSG;
               end
            end
            PH_MSG: begin
               if (period_end) begin
                  q_wr.push           = 1'b1;
                  q_wr.entry.data_bit = dec_bit;
                  q_wr.entry.bit_index = br_ff;
                  mis_in              = mis_acc;
                  br_in               = br_inc;
                  if (br_inc >= eff_len) begin
                     done_in                  = done_inc;
                     q_wr.entry.last          = 1'b1;
                     q_wr.entry.bit_errors    = mis_acc;
                     q_wr.entry.message_count = done_inc;
                     phase_in                 = PH_IDLE;
                     br_in                    = '0;
                     mis_in                   = '0;
                     expect_in                = 1'b1;
                     bc_in                    = '0;
                  end
               end
            end
            default: begin
               phase_in = PH_UNSYNC;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_UNSYNC;
         sc_ff     <= '0;
         ones_ff   <= '0;
         bc_ff     <= '0;
         quiet_ff  <= 1'b1;
         expect_ff <= 1'b1;
         br_ff     <= '0;
         mis_ff    <= '0;
         done_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         sc_ff     <= sc_in;
         ones_ff   <= ones_in;
         bc_ff     <= bc_in;
         quiet_ff  <= quiet_in;
         expect_ff <= expect_in;
         br_ff     <= br_in;
         mis_ff    <= mis_in;
         done_ff   <= done_in;
      end
   end

   // A message bit can only leave while a message is open
   a_push_phase: assert property (@(posedge clock) disable iff (reset)
      (q_wr.push && !q_wr.entry.burst) |-> (phase_ff == PH_MSG))
      else $error("bps_slicer: single beat pushed outside a message");

   // A preamble burst always opens a message at the preamble length
   a_burst_open: assert property (@(posedge clock) disable iff (reset)
      (q_wr.push && q_wr.entry.burst) |=> (phase_ff == PH_MSG && br_ff == PRE_IDX))
      else $error("bps_slicer: burst did not open a message");

   // Nothing is processed while the queue is full
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_wr.push)
      else $error("bps_slicer: push while queue full");

endmodule

@@ src/bps_queue.sv @@
// Result queue that expands preamble bursts into single beats
module bps_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  bps_pkg::q_write_type          q_wr,
   output logic                          q_full,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_data_bit,
   output logic [bps_pkg::LEN_W-1:0]     rsp_bit_index,
   output logic                          rsp_last,
   output logic [bps_pkg::ERR_W-1:0]     rsp_bit_errors,
   output logic [bps_pkg::MCNT_W-1:0]    rsp_message_count
);
   import bps_pkg::*;

   localparam logic [BURST_W-1:0]  BURST_LAST = BURST_W'(PREAMBLE_BITS - 1);
   localparam logic [Q_PTR_W-1:0]  PTR_LAST   = Q_PTR_W'(Q_DEPTH - 1);
   localparam logic [Q_CNT_W-1:0]  CNT_FULL   = Q_CNT_W'(Q_DEPTH);

   q_entry_type         entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BURST_W-1:0]  burst_ff, burst_in;
   q_entry_type         head;
   logic                beat;
   logic                pop;

   assign q_full    = (cnt_ff == CNT_FULL);
   assign rsp_valid = (cnt_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];
   assign beat      = rsp_valid & ~rsp_stall;
   assign pop       = beat & (~head.burst | (burst_ff == BURST_LAST));

   // Present the head entry, or the current preamble beat of a burst
   always_comb begin
      if (head.burst) begin
         rsp_data_bit      = ~burst_ff[0];
         rsp_bit_index     = LEN_W'(burst_ff);
         rsp_last          = 1'b0;
         rsp_bit_errors    = '0;
         rsp_message_count = '0;
      end else begin
         rsp_data_bit      = head.data_bit;
         rsp_bit_index     = head.bit_index;
         rsp_last          = head.last;
         rsp_bit_errors    = head.bit_errors;
         rsp_message_count = head.message_count;
      end
   end

   // Advance pointers, fill count and burst position
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      burst_in  = burst_ff;
      if (q_wr.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
         burst_in  = '0;
      end else if (beat) begin
         burst_in = burst_ff + BURST_W'(1);
      end
      case ({q_wr.push, pop})
         2'b10:   cnt_in = cnt_ff + Q_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - Q_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         burst_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         burst_ff  <= burst_in;
      end
      if (q_wr.push) begin
         entries_ff[wr_ptr_ff] <= q_wr.entry;
      end
   end

   // Fill count never passes the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("bps_queue: fill count above depth");

   // A burst position is only held while a burst sits at the head
   a_burst_head: assert property (@(posedge clock) disable iff (reset)
      (burst_ff != '0) |-> (rsp_valid && head.burst))
      else $error("bps_queue: burst position without burst entry");

   // Pointers meet whenever the queue is empty or full
   a_ptr_cnt: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == CNT_FULL) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("bps_queue: pointers out of step with fill count");

endmodule

@@ src/bit_slicer_preamble_sync_core.sv @@
// Top level of the integrate-and-dump bit slicer with preamble sync
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  req      | req_valid / req_stall | req_sample_bit
//  rsp      | rsp_valid / rsp_stall | rsp_data_bit, rsp_bit_index, rsp_last,
//           |                       | rsp_bit_errors, rsp_message_count
//  csr      | csr_valid / csr_ready | csr_index, csr_data (always ready)
//
// One sample is taken every cycle while req_stall is low; it is held in the sample
// register, and its result beat, if any, leaves the queue when rsp_stall is low.
// A preamble yields PREAMBLE_BITS beats from one entry, one per unstalled cycle.
// req_stall rises only while the four-entry result queue is full and a sample waits.
// Synchronous reset returns to the unsynchronised phase with register defaults.
module bit_slicer_preamble_sync_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_sample_bit,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_data_bit,
   output logic [bps_pkg::LEN_W-1:0]   rsp_bit_index,
   output logic                        rsp_last,
   output logic [bps_pkg::ERR_W-1:0]   rsp_bit_errors,
   output logic [bps_pkg::MCNT_W-1:0]  rsp_message_count,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bps_pkg::CIDX_W-1:0]  csr_index,
   input  logic [bps_pkg::CSR_W-1:0]   csr_data
);
   import bps_pkg::*;

   q_write_type q_wr;
   logic        q_full;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;

   bps_slicer u_slicer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_bit (req_sample_bit),
      .csr_valid      (csr_valid & csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_full         (q_full),
      .q_wr           (q_wr)
   );

   bps_queue u_queue (
      .clock             (clock),
      .reset             (reset),
      .q_wr              (q_wr),
      .q_full            (q_full),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_bit      (rsp_data_bit),
      .rsp_bit_index     (rsp_bit_index),
      .rsp_last          (rsp_last),
      .rsp_bit_errors    (rsp_bit_errors),
      .rsp_message_count (rsp_message_count)
   );

endmodule

@@ test/bit_slicer_preamble_sync_core_tb.sv @@
// Self-checking testbench for the bit slicer with preamble sync: predicts every beat and checks it
module bit_slicer_preamble_sync_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bps_pkg::*;

   localparam int RESET_CYCLES = 7;
   // Sample register plus queue output stage, with margin
   localparam int DRAIN_CYCLES = 10;
   // Long receiver hold-off, enough to fill the result queue and stall the input
   localparam int HOLD_CYCLES  = 40;
   // About 120 samples and a few hundred beats at the slowest idling: ample headroom
   localparam int unsigned CYCLE_LIMIT = 20_000;
   // Unused register slot; writes to it must change nothing
   localparam logic [CIDX_W-1:0] CSR_SPARE = 2'd3;
   // One sample per bit: a one while unsynchronised, a quiet resync, a broken
   // preamble, the full preamble and a single payload bit
   localparam int        OPENING_LEN = 25;
   localparam bit [0:24] OPENING     = 25'b1000000000101011010101010;

   typedef enum logic [1:0] {
      SYNC_HUNT,
      PREAMBLE_SEARCH,
      IN_MESSAGE
   } slicer_phase_type;

   typedef struct packed {
      bit              data_bit;
      bit [LEN_W-1:0]  bit_index;
      bit              last;
      bit [ERR_W-1:0]  bit_errors;
      bit [MCNT_W-1:0] message_count;
   } slice_beat_type;

   // Slicer state mirror and queue of beats still due from the block
   class slicer_scoreboard;
      bit [SPB_W-1:0]   spb;
      bit [THR_W-1:0]   thr;
      bit [LEN_W-1:0]   len_reg;
      slicer_phase_type phase;
      bit [SPB_W-1:0]   sample_cnt;
      bit [SPB_W-1:0]   ones_cnt;
      bit [BC_W-1:0]    bit_cnt;
      bit               quiet;
      bit               want_one;
      bit [LEN_W-1:0]   bits_rx;
      bit [ERR_W-1:0]   err_cnt;
      bit [MCNT_W-1:0]  msg_cnt;
      int unsigned      messages_out;
      int unsigned      fail_count;
      slice_beat_type   due_beats[$];

      function new();
         spb          = SPB_W'(8);
         thr          = THR_W'(4);
         len_reg      = LEN_W'(64);
         phase        = SYNC_HUNT;
         sample_cnt   = '0;
         ones_cnt     = '0;
         bit_cnt      = '0;
         quiet        = 1'b1;
         want_one     = 1'b1;
         bits_rx      = '0;
         err_cnt      = '0;
         msg_cnt      = '0;
         messages_out = 0;
         fail_count   = 0;
      endfunction

      function void write_reg(bit [CIDX_W-1:0] idx, bit [CSR_W-1:0] data);
         case (idx)
            CSR_SAMPLES_PER_BIT: spb     = data[SPB_W-1:0];
            CSR_BIT_THRESHOLD:   thr     = data[THR_W-1:0];
            CSR_MSG_LENGTH:      len_reg = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // Samples until the current bit period closes (counter may have to wrap)
      function int samples_left();
         bit [SPB_W-1:0] span;
         span = spb - sample_cnt - 1'b1;
         return int'(span) + 1;
      endfunction

      // Integrate one sample, advance the sync state and queue any beats it yields
      function void take_sample(bit s);
         bit             period_end;
         bit             decided;
         bit [LEN_W-1:0] eff_len;
         bit [LEN_W-1:0] idx;
         slice_beat_type beat;
         decided    = 1'b0;
         sample_cnt = sample_cnt + 1'b1;
         if (s && ones_cnt != '1) ones_cnt = ones_cnt + 1'b1;
         period_end = (sample_cnt == spb);
         if (period_end) begin
            decided    = (ones_cnt >= thr);
            sample_cnt = '0;
            ones_cnt   = '0;
         end
         eff_len = (len_reg < PREAMBLE_BITS + 1) ? LEN_W'(PREAMBLE_BITS + 1) : len_reg;

         case (phase)
            SYNC_HUNT: begin
               if (period_end) begin
                  bit_cnt = bit_cnt + 1'b1;
                  if (decided) quiet = 1'b0;
               end
               if (bit_cnt >= QUIET_BITS) begin
                  bit_cnt = '0;
                  if (quiet) phase = PREAMBLE_SEARCH;
                  else quiet = 1'b1;
               end
            end
            PREAMBLE_SEARCH: begin
               // a wrong bit restarts the count but keeps the expected polarity
               if (period_end) begin
                  if (decided == want_one) begin
                     bit_cnt  = bit_cnt + 1'b1;
                     want_one = ~decided;
                  end else begin
                     bit_cnt = '0;
                  end
               end
               if (bit_cnt == PREAMBLE_BITS) begin
                  for (int i = 0; i < PREAMBLE_BITS; i++) begin
                     beat           = '0;
                     beat.data_bit  = ~i[0];
                     beat.bit_index = LEN_W'(i);
                     due_beats      = {due_beats, beat};
                  end
                  bit_cnt = '0;
                  bits_rx = LEN_W'(PREAMBLE_BITS);
                  err_cnt = '0;
                  phase   = IN_MESSAGE;
               end
            end
            default: begin
               if (period_end) begin
                  idx = bits_rx;
                  // pattern bit is one on even positions
                  if (decided == idx[0]) err_cnt = err_cnt + 1'b1;
                  bits_rx        = bits_rx + 1'b1;
                  beat           = '0;
                  beat.data_bit  = decided;
                  beat.bit_index = idx;
                  if (bits_rx >= eff_len) begin
                     msg_cnt            = msg_cnt + 1'b1;
                     beat.last          = 1'b1;
                     beat.bit_errors    = err_cnt;
                     beat.message_count = msg_cnt;
                     messages_out++;
                     phase    = PREAMBLE_SEARCH;
                     bits_rx  = '0;
                     err_cnt  = '0;
                     want_one = 1'b1;
                     bit_cnt  = '0;
                  end
                  due_beats = {due_beats, beat};
               end
            end
         endcase
      endfunction

      // Compare a delivered beat against the oldest one due
      function void check_beat(slice_beat_type got);
         slice_beat_type want;
         if (due_beats.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected beat bit %0d index %0d last %0d errors %0d count %0d",
                        $realtime, got.data_bit, got.bit_index, got.last, got.bit_errors,
                        got.message_count);
            return;
         end
         want = due_beats.pop_front();
         if (want.data_bit != got.data_bit || want.bit_index != got.bit_index ||
             want.last != got.last || want.bit_errors != got.bit_errors ||
             want.message_count != got.message_count) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: beat mismatch expected bit %0d index %0d last %0d errors %0d count %0d",
                        $realtime, want.data_bit, want.bit_index, want.last, want.bit_errors,
                        want.message_count);
               $display("%0t:                  got bit %0d index %0d last %0d errors %0d count %0d",
                        $realtime, got.data_bit, got.bit_index, got.last, got.bit_errors,
                        got.message_count);
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_sample_bit;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_data_bit;
   logic [LEN_W-1:0]   rsp_bit_index;
   logic               rsp_last;
   logic [ERR_W-1:0]   rsp_bit_errors;
   logic [MCNT_W-1:0]  rsp_message_count;
   logic               csr_valid;
   logic               csr_ready;
   logic [CIDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]   csr_data;

   slicer_scoreboard sb = new();
   int unsigned      sender_idle_pct;
   int unsigned      receiver_stall_pct;
   bit               hold_req;
   int unsigned      cycle_count;

   bit_slicer_preamble_sync_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_bit    (req_sample_bit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_bit      (rsp_data_bit),
      .rsp_bit_index     (rsp_bit_index),
      .rsp_last          (rsp_last),
      .rsp_bit_errors    (rsp_bit_errors),
      .rsp_message_count (rsp_message_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // End the run if it overruns the cycle budget
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bit_slicer_preamble_sync_core_tb: FAIL");
      $finish;
   end

   // Receive and check result beats; stall at random or hold off on request
   initial begin
      int unsigned    hold_left;
      slice_beat_type beat;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            beat.data_bit      = rsp_data_bit;
            beat.bit_index     = rsp_bit_index;
            beat.last          = rsp_last;
            beat.bit_errors    = rsp_bit_errors;
            beat.message_count = rsp_message_count;
            sb.check_beat(beat);
         end
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
         end
      end
   end

   // Offer one sample, idling first at random; hold it until accepted
   task automatic send_sample(input bit s);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid      <= 1'b0;
         req_sample_bit <= 1'($urandom_range(1, 0));
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample_bit <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_sample(s);
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) send_sample(1'($urandom_range(1, 0)));
   endtask

   // Finish the current bit period with a ones count that decides the wanted bit
   task automatic send_period(input bit value);
      int left;
      int have;
      int thr_i;
      int lo;
      int hi;
      int ones_to_go;
      bit s;
      left  = sb.samples_left();
      have  = int'(sb.ones_cnt);
      thr_i = int'(sb.thr);
      if (value) begin
         lo = (thr_i > have) ? thr_i - have : 0;
         hi = left;
         if (lo > hi) lo = hi;
      end else begin
         lo = 0;
         hi = thr_i - have - 1;
         if (hi < 0) hi = 0;
         if (hi > left) hi = left;
      end
      ones_to_go = $urandom_range(hi, lo);
      // scatter the ones over the remaining samples
      for (int i = left; i > 0; i--) begin
         s = ($urandom_range(i - 1, 0) < ones_to_go);
         if (s) ones_to_go--;
         send_sample(s);
      end
   endtask

   // Drive quiet periods, then the preamble with occasional broken bits, then a
   // random payload, until enough messages close or the period budget runs out
   task automatic run_messages(input int n_msgs, input int max_periods);
      int unsigned done_before;
      int          periods;
      bit          want;
      done_before = sb.messages_out;
      periods     = 0;
      while (sb.messages_out - done_before < n_msgs && periods < max_periods) begin
         case (sb.phase)
            SYNC_HUNT:       want = ($urandom_range(99, 0) < 5);
            PREAMBLE_SEARCH: want = sb.want_one ^ ($urandom_range(99, 0) < 6);
            default:         want = 1'($urandom_range(1, 0));
         endcase
         send_period(want);
         periods++;
      end
   endtask

   // Drop valid and wait for every due beat, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.due_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; valid stays high so writes can follow back to back
   task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned value);
      logic [CSR_W-1:0] data;
      data = CSR_W'(value);
      // upper bits are ignored by the narrower registers: randomise them
      if (idx != CSR_MSG_LENGTH) data[CSR_W-1:SPB_W] = 2'($urandom_range(3, 0));
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(input int unsigned spb_v, input int unsigned thr_v,
                            input int unsigned len_v);
      write_reg(CSR_SAMPLES_PER_BIT, spb_v);
      write_reg(CSR_BIT_THRESHOLD, thr_v);
      write_reg(CSR_MSG_LENGTH, len_v);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_sample_bit <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_SAMPLES_PER_BIT;
      csr_data       <= '0;
      hold_req           = 1'b0;
      sender_idle_pct    = 10;
      receiver_stall_pct = 52;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: one sample per bit, shortest message
      configure(1, 1, 0);
      for (int i = 0; i < OPENING_LEN; i++) send_sample(OPENING[i]);
      settle();

      // Two samples per bit with random preamble breaks and payload
      configure(2, 1, 12);
      run_messages(1, 16);
      settle();

      sender_idle_pct    = 52;
      receiver_stall_pct = 10;

      // Longest message, then lower the length while it is open
      configure(1, 1, 4095);
      run_messages(1, 12);
      settle();
      write_reg(CSR_MSG_LENGTH, 0);
      csr_valid <= 1'b0;
      run_messages(1, 12);
      settle();

      // Zero threshold decides every period as a one; poke the spare slot
      configure(2, 0, 9);
      send_noise(8);
      settle();
      write_reg(CSR_SPARE, $urandom_range(4095, 0));
      csr_valid <= 1'b0;

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;

      // Hold the receiver off while samples keep coming, so the queue fills
      configure(1, 1, 12);
      hold_req = 1'b1;
      run_messages(2, 30);
      settle();

      if (sb.fail_count == 0 && sb.due_beats.size() == 0) begin
         $display("bit_slicer_preamble_sync_core_tb: PASS");
      end else begin
         $display("bit_slicer_preamble_sync_core_tb: FAIL");
      end
      $finish;
   end

endmodule
